// ===== hw/rtl/bpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_pkg - buddy page allocator package
// Payload types, codes and bitmap layout helpers.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int unsigned NUM_PAGES   = 4096;
    localparam int unsigned MAX_ORDER_P = 10;
    localparam int unsigned MAP_ROWS    = 258;   // 32-bit rows over orders 0..10

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_INVAL  = 2'd1,
        ST_NOMEM  = 2'd2,
        ST_DOUBLE = 2'd3
    } t_status;

    typedef struct packed {
        logic        op;
        logic [12:0] page_count;
        logic [12:0] align_pages;
        logic [11:0] start_page;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [11:0] block_page;
        logic [12:0] grant_pages;
        logic [12:0] pages_free;
    } t_rsp;

    // first row of each order in the bitmap memory
    function automatic logic [8:0] f_row_base(input logic [3:0] k);
        logic [8:0] r;
        case (k)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd128;
            4'd2:    r = 9'd192;
            4'd3:    r = 9'd224;
            4'd4:    r = 9'd240;
            4'd5:    r = 9'd248;
            4'd6:    r = 9'd252;
            4'd7:    r = 9'd254;
            4'd8:    r = 9'd255;
            4'd9:    r = 9'd256;
            4'd10:   r = 9'd257;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // last row offset within an order
    function automatic logic [6:0] f_last_row(input logic [3:0] k);
        logic [6:0] r;
        case (k)
            4'd0:    r = 7'd127;
            4'd1:    r = 7'd63;
            4'd2:    r = 7'd31;
            4'd3:    r = 7'd15;
            4'd4:    r = 7'd7;
            4'd5:    r = 7'd3;
            4'd6:    r = 7'd1;
            default: r = 7'd0;
        endcase
        return r;
    endfunction

    function automatic logic [8:0] f_row_addr(input logic [3:0] k, input logic [11:0] idx);
        return f_row_base(k) + {2'b00, idx[11:5]};
    endfunction

    // index of lowest set bit
    function automatic logic [4:0] f_ctz32(input logic [31:0] v);
        logic [4:0] r;
        r = 5'd0;
        for (int i = 31; i >= 0; i--) begin
            if (v[i]) r = 5'(i);
        end
        return r;
    endfunction

    // index of highest set bit
    function automatic logic [3:0] f_flog2(input logic [12:0] v);
        logic [3:0] r;
        r = 4'd0;
        for (int i = 0; i < 13; i++) begin
            if (v[i]) r = 4'(i);
        end
        return r;
    endfunction

    function automatic logic [3:0] f_clog2(input logic [12:0] v);
        logic [3:0] r;
        if (v <= 13'd1) r = 4'd0;
        else            r = f_flog2(v - 13'd1) + 4'd1;
        return r;
    endfunction

    // largest aligned block order at address a within n pages, capped
    function automatic logic [3:0] f_range_order(input logic [12:0] a, input logic [12:0] n);
        logic [3:0] tz;
        logic [3:0] fl;
        logic [3:0] r;
        tz = 4'(MAX_ORDER_P);
        for (int i = int'(MAX_ORDER_P) - 1; i >= 0; i--) begin
            if (a[i]) tz = 4'(i);
        end
        fl = f_flog2(n);
        r  = (fl < tz) ? fl : tz;
        if (r > 4'(MAX_ORDER_P)) r = 4'(MAX_ORDER_P);
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/buddy_page_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// buddy_page_allocator - buddy allocator over 4096 page frames
// Bitmap per order in one 258 x 32 memory, walked by a small sequencer.
// ----------------------------------------------------------------------------
// A request transfers when start is high and busy is low; its single result
// appears on o_rsp for one cycle with o_valid and must be taken then, as the
// receiver cannot stall it. After reset the block runs a clearing pass over
// all 258 bitmap rows with busy high. The bitmap memory has a registered
// read, so every bitmap access is a read state followed by an evaluate or
// write-back state. An allocate scans rows from its own order upward (up to
// 258 rows when it searches every order from 0 to 10), then splits the found
// block level by level down to the requested order and releases any unused
// tail; a free first checks the rows of every order that the range covers,
// then releases the range block by block, probing buddies to merge each
// block upward, and ends with the result state.
module buddy_page_allocator
    import bpa_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_req i_req,
    output logic      busy,
    output logic      o_valid,
    output t_rsp      o_rsp
);

    typedef enum logic [14:0] {
        S_CLEAR    = 15'b000000000000001,
        S_IDLE     = 15'b000000000000010,
        S_SRCH_RD  = 15'b000000000000100,
        S_SRCH_CHK = 15'b000000000001000,
        S_SPLIT_RD = 15'b000000000010000,
        S_SPLIT_WR = 15'b000000000100000,
        S_TAIL     = 15'b000000001000000,
        S_CHK_RD   = 15'b000000010000000,
        S_CHK_EVAL = 15'b000000100000000,
        S_RANGE    = 15'b000001000000000,
        S_BUD_RD   = 15'b000010000000000,
        S_BUD_EVAL = 15'b000100000000000,
        S_SET_RD   = 15'b001000000000000,
        S_SET_WR   = 15'b010000000000000,
        S_DONE     = 15'b100000000000000
    } t_state;

    t_state      r_state, n_state;
    logic [8:0]  r_clr, n_clr;
    logic [3:0]  r_k, n_k;          // requested order
    logic [3:0]  r_f, n_f;          // working order (search, split, check)
    logic [6:0]  r_row, n_row;
    logic [11:0] r_ba, n_ba;        // block address being placed
    logic [3:0]  r_bk, n_bk;        // block order being placed
    logic [12:0] r_ra, n_ra;        // range cursor
    logic [12:0] r_rn, n_rn;        // pages left in range
    logic [12:0] r_cnt, n_cnt;
    logic [11:0] r_lo, n_lo;
    logic [11:0] r_hi, n_hi;
    logic [12:0] r_total, n_total;
    t_status     r_status, n_status;
    logic [11:0] r_bpage, n_bpage;
    logic [12:0] r_bpages, n_bpages;

    // bitmap memory
    logic [31:0] mem [MAP_ROWS];
    logic [31:0] r_rdata;
    logic        mem_we;
    logic [8:0]  mem_waddr, mem_raddr;
    logic [31:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        r_rdata <= mem[mem_raddr];
    end

    // request decode
    logic [12:0] req_max;
    logic [3:0]  req_ord;
    logic        req_bad;
    logic [13:0] req_end;

    assign req_max = (i_req.page_count > i_req.align_pages) ? i_req.page_count
                                                            : i_req.align_pages;
    assign req_ord = f_clog2(req_max);
    assign req_bad = (i_req.page_count == 13'd0) || (i_req.align_pages == 13'd0)
                   || ((i_req.align_pages & (i_req.align_pages - 13'd1)) != 13'd0);
    assign req_end = {2'b00, i_req.start_page} + {1'b0, i_req.page_count};

    // per-state helpers
    logic [11:0] idx_found, split_idx, bud, bud_idx, set_idx, lo_i, hi_i;
    logic [4:0]  pos, lo_off, hi_off;
    logic [31:0] chk_mask;
    logic [3:0]  rng_ord;
    logic [12:0] tail_size;

    always_comb begin
        pos       = f_ctz32(r_rdata);
        idx_found = {r_row, pos};
        split_idx = (r_ba >> r_f) + 12'd1;
        bud       = r_ba ^ (12'd1 << r_bk);
        bud_idx   = bud >> r_bk;
        set_idx   = r_ba >> r_bk;
        lo_i      = r_lo >> r_f;
        hi_i      = r_hi >> r_f;
        lo_off    = (r_row == lo_i[11:5]) ? lo_i[4:0] : 5'd0;
        hi_off    = (r_row == hi_i[11:5]) ? hi_i[4:0] : 5'd31;
        chk_mask  = ({32{1'b1}} << lo_off) & ({32{1'b1}} >> (5'd31 - hi_off));
        rng_ord   = f_range_order(r_ra, r_rn);
        tail_size = 13'd1 << r_k;
    end

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_k      = r_k;
        n_f      = r_f;
        n_row    = r_row;
        n_ba     = r_ba;
        n_bk     = r_bk;
        n_ra     = r_ra;
        n_rn     = r_rn;
        n_cnt    = r_cnt;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_total  = r_total;
        n_status = r_status;
        n_bpage  = r_bpage;
        n_bpages = r_bpages;
        mem_we    = 1'b0;
        mem_waddr = 9'd0;
        mem_wdata = 32'd0;
        mem_raddr = 9'd0;

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                if (r_clr == 9'(MAP_ROWS - 1)) n_state = S_IDLE;
                else                           n_clr   = r_clr + 9'd1;
            end
            S_IDLE: begin
                if (start) begin
                    n_cnt    = i_req.page_count;
                    n_status = ST_OK;
                    n_bpage  = 12'd0;
                    n_bpages = 13'd0;
                    if (i_req.op == OP_ALLOC) begin
                        if (req_bad) begin
                            n_status = ST_INVAL;
                            n_state  = S_DONE;
                        end else if (req_ord > 4'(MAX_ORDER_P)) begin
                            n_status = ST_NOMEM;
                            n_state  = S_DONE;
                        end else begin
                            n_k     = req_ord;
                            n_f     = req_ord;
                            n_row   = 7'd0;
                            n_state = S_SRCH_RD;
                        end
                    end else begin
                        if (req_end > 14'(NUM_PAGES)) begin
                            n_status = ST_INVAL;
                            n_state  = S_DONE;
                        end else if (i_req.page_count == 13'd0) begin
                            n_rn    = 13'd0;
                            n_state = S_RANGE;
                        end else begin
                            n_lo    = i_req.start_page;
                            n_hi    = 12'(req_end - 14'd1);
                            n_f     = 4'd0;
                            n_row   = i_req.start_page[11:5];
                            n_state = S_CHK_RD;
                        end
                    end
                end
            end
            S_SRCH_RD: begin
                mem_raddr = f_row_base(r_f) + {2'b00, r_row};
                n_state   = S_SRCH_CHK;
            end
            S_SRCH_CHK: begin
                if (r_rdata != 32'd0) begin
                    // take the lowest free block and clear its bit
                    mem_we    = 1'b1;
                    mem_waddr = f_row_base(r_f) + {2'b00, r_row};
                    mem_wdata = r_rdata & ~(32'd1 << pos);
                    n_total   = r_total - (13'd1 << r_f);
                    n_ba      = idx_found << r_f;
                    if (r_f > r_k) begin
                        n_f     = r_f - 4'd1;
                        n_state = S_SPLIT_RD;
                    end else begin
                        n_state = S_TAIL;
                    end
                end else if (r_row != f_last_row(r_f)) begin
                    n_row   = r_row + 7'd1;
                    n_state = S_SRCH_RD;
                end else if (r_f != 4'(MAX_ORDER_P)) begin
                    n_f     = r_f + 4'd1;
                    n_row   = 7'd0;
                    n_state = S_SRCH_RD;
                end else begin
                    n_status = ST_NOMEM;
                    n_state  = S_DONE;
                end
            end
            S_SPLIT_RD: begin
                mem_raddr = f_row_addr(r_f, split_idx);
                n_state   = S_SPLIT_WR;
            end
            S_SPLIT_WR: begin
                // upper half goes free, low half is kept
                mem_we    = 1'b1;
                mem_waddr = f_row_addr(r_f, split_idx);
                mem_wdata = r_rdata | (32'd1 << split_idx[4:0]);
                n_total   = r_total + (13'd1 << r_f);
                if (r_f > r_k) begin
                    n_f     = r_f - 4'd1;
                    n_state = S_SPLIT_RD;
                end else begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                n_bpage  = r_ba;
                n_bpages = r_cnt;
                if (tail_size > r_cnt) begin
                    n_ra    = {1'b0, r_ba} + r_cnt;
                    n_rn    = tail_size - r_cnt;
                    n_state = S_RANGE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CHK_RD: begin
                mem_raddr = f_row_base(r_f) + {2'b00, r_row};
                n_state   = S_CHK_EVAL;
            end
            S_CHK_EVAL: begin
                if ((r_rdata & chk_mask) != 32'd0) begin
                    n_status = ST_DOUBLE;
                    n_state  = S_DONE;
                end else if (r_row != hi_i[11:5]) begin
                    n_row   = r_row + 7'd1;
                    n_state = S_CHK_RD;
                end else if (r_f != 4'(MAX_ORDER_P)) begin
                    n_f     = r_f + 4'd1;
                    n_row   = lo_i[11:5] >> 1;
                    n_state = S_CHK_RD;
                end else begin
                    n_ra    = {1'b0, r_lo};
                    n_rn    = r_cnt;
                    n_state = S_RANGE;
                end
            end
            S_RANGE: begin
                if (r_rn == 13'd0) begin
                    n_state = S_DONE;
                end else begin
                    n_ba = r_ra[11:0];
                    n_bk = rng_ord;
                    n_ra = r_ra + (13'd1 << rng_ord);
                    n_rn = r_rn - (13'd1 << rng_ord);
                    if (rng_ord != 4'(MAX_ORDER_P)) n_state = S_BUD_RD;
                    else                            n_state = S_SET_RD;
                end
            end
            S_BUD_RD: begin
                mem_raddr = f_row_addr(r_bk, bud_idx);
                n_state   = S_BUD_EVAL;
            end
            S_BUD_EVAL: begin
                if (r_rdata[bud_idx[4:0]]) begin
                    // buddy free: absorb it and climb one order
                    mem_we    = 1'b1;
                    mem_waddr = f_row_addr(r_bk, bud_idx);
                    mem_wdata = r_rdata & ~(32'd1 << bud_idx[4:0]);
                    n_total   = r_total - (13'd1 << r_bk);
                    if (bud < r_ba) n_ba = bud;
                    n_bk = r_bk + 4'd1;
                    if (r_bk + 4'd1 != 4'(MAX_ORDER_P)) n_state = S_BUD_RD;
                    else                                n_state = S_SET_RD;
                end else begin
                    n_state = S_SET_RD;
                end
            end
            S_SET_RD: begin
                mem_raddr = f_row_addr(r_bk, set_idx);
                n_state   = S_SET_WR;
            end
            S_SET_WR: begin
                mem_we    = 1'b1;
                mem_waddr = f_row_addr(r_bk, set_idx);
                mem_wdata = r_rdata | (32'd1 << set_idx[4:0]);
                n_total   = r_total + (13'd1 << r_bk);
                n_state   = S_RANGE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= 9'd0;
            r_total <= 13'd0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_f      <= n_f;
        r_row    <= n_row;
        r_ba     <= n_ba;
        r_bk     <= n_bk;
        r_ra     <= n_ra;
        r_rn     <= n_rn;
        r_cnt    <= n_cnt;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_status <= n_status;
        r_bpage  <= n_bpage;
        r_bpages <= n_bpages;
    end

    assign busy                 = (r_state != S_IDLE);
    assign o_valid              = (r_state == S_DONE);
    assign o_rsp.status         = r_status;
    assign o_rsp.block_page     = r_bpage;
    assign o_rsp.grant_pages    = r_bpages;
    assign o_rsp.pages_free     = r_total;

    // result strobe is a single-cycle pulse
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe held");

    // an accepted request always occupies the block
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("request transfer not taken");

    // free page count never exceeds the pool
    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= 13'(NUM_PAGES)) else $error("free page count overflow");

    // bitmap writes stay inside the memory
    a_waddr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (mem_waddr < 9'(MAP_ROWS))) else $error("bitmap write out of range");

    // only a successful allocate grants pages
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status != ST_OK) |-> (o_rsp.grant_pages == 13'd0))
        else $error("pages granted on failure");

endmodule
`default_nettype wire
